/* rtl/lome_pkg.sv */
// Shared types and constants of the limit order matching engine.
package lome_pkg;

  localparam int BOOK_DEPTH = 16;
  localparam int IDX_W      = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

  localparam logic [2:0] EXEC_NEW      = 3'd0;
  localparam logic [2:0] EXEC_PARTIAL  = 3'd1;
  localparam logic [2:0] EXEC_FILL     = 3'd2;
  localparam logic [2:0] EXEC_CANCELED = 3'd3;
  localparam logic [2:0] EXEC_REJECTED = 3'd4;

  localparam logic [1:0] REJ_NONE      = 2'd0;
  localparam logic [1:0] REJ_QUANTITY  = 2'd1;
  localparam logic [1:0] REJ_PRICE     = 2'd2;
  localparam logic [1:0] REJ_NOT_FOUND = 2'd3;

  localparam logic [1:0] KIND_LIMIT = 2'd0;
  localparam logic       CMD_NEW    = 1'b0;

  typedef struct packed {
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        leaves;
    logic [31:0]        engine_id;
    logic [31:0]        client;
    logic [31:0]        client_order;
    logic [31:0]        arrival;
  } slot_t;

  typedef struct packed {
    logic             wr_all;
    logic             wr_leaves;
    logic             clr_valid;
    logic [IDX_W-1:0] idx;
    slot_t            data;
  } book_cmd_t;

  typedef struct packed {
    logic  valid;
    slot_t data;
  } book_rd_t;

  typedef struct packed {
    logic [31:0]        client;
    logic [31:0]        client_order;
    logic [31:0]        order;
    logic [2:0]         kind;
    logic signed [31:0] price;
    logic [31:0]        fill;
    logic [31:0]        leaves;
    logic [1:0]         code;
  } rpt_t;

  typedef struct packed {
    logic emit_ok;
    logic flush_ok;
  } rpt_stat_t;

endpackage

/* rtl/lome_book.sv */
// Resting order slots with valid bits, one read and one write index.
module lome_book (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [lome_pkg::IDX_W-1:0] rd_idx,
  input  lome_pkg::book_cmd_t cmd,
  output lome_pkg::book_rd_t  rd
);
  import lome_pkg::*;

  logic [BOOK_DEPTH-1:0] valid_r;
  slot_t                 slot_r [BOOK_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.wr_all) begin
      valid_r[cmd.idx] <= 1'b1;
    end else if (cmd.clr_valid) begin
      valid_r[cmd.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_all) begin
      slot_r[cmd.idx] <= cmd.data;
    end else if (cmd.wr_leaves) begin
      slot_r[cmd.idx].leaves <= cmd.data.leaves;
    end
  end

  assign rd.valid = valid_r[rd_idx];
  assign rd.data  = slot_r[rd_idx];

endmodule

/* rtl/lome_out.sv */
// Report staging: one held report plus the output register, serial numbering.
module lome_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                emit,
  input  lome_pkg::rpt_t      rpt,
  input  logic                flush,
  output lome_pkg::rpt_stat_t stat,
  output logic                out_valid,
  input  logic                out_stall,
  output lome_pkg::rpt_t      out_rpt,
  output logic [31:0]         out_serial,
  output logic                out_last
);
  import lome_pkg::*;

  logic        pend_v_r;
  rpt_t        pend_r;
  logic [31:0] pend_serial_r;
  logic [31:0] serial_r;
  logic        out_v_r;
  rpt_t        out_r;
  logic [31:0] out_serial_r;
  logic        out_last_r;
  logic        out_free;

  assign out_free      = !out_v_r || !out_stall;
  assign stat.emit_ok  = !pend_v_r || out_free;
  assign stat.flush_ok = !pend_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      serial_r <= 32'd1;
    end else begin
      if (emit && stat.emit_ok) begin
        if (pend_v_r) begin
          out_r        <= pend_r;
          out_serial_r <= pend_serial_r;
          out_last_r   <= 1'b0;
          out_v_r      <= 1'b1;
        end else if (!out_stall) begin
          out_v_r <= 1'b0;
        end
        pend_r        <= rpt;
        pend_serial_r <= serial_r;
        pend_v_r      <= 1'b1;
        serial_r      <= serial_r + 32'd1;
      end else if (flush && pend_v_r && out_free) begin
        out_r        <= pend_r;
        out_serial_r <= pend_serial_r;
        out_last_r   <= 1'b1;
        out_v_r      <= 1'b1;
        pend_v_r     <= 1'b0;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_v_r;
  assign out_rpt    = out_r;
  assign out_serial = out_serial_r;
  assign out_last   = out_last_r;

endmodule

/* rtl/limit_order_matching_engine.sv */
// Top level: order sequencer with shared slot compare unit.
//
// Input channel in_*: one transaction is a new order or a cancel. in_stall
// stays high while a transaction is processed, so one is taken at a time.
// Output channel out_*: one transaction per execution report, in order;
// out_last_report marks the final report of an input.
// Each match step scans all BOOK_DEPTH slots, one per cycle through the
// single slot read port and compare unit, then decides in ST_DECIDE and
// writes the maker report in ST_MAKER and the taker report in ST_TAKER.
// Reports pass a one-deep hold stage and the output register; a stalled
// receiver holds out_* and pauses the sequencer when both are full.
// Reset (rst_n low, synchronous) empties the book and sets engine id and
// report serial to one; no clearing pass is needed.
module limit_order_matching_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic               in_side,
  input  logic [1:0]         in_order_kind,
  input  logic signed [31:0] in_limit_price,
  input  logic [31:0]        in_quantity,
  input  logic [31:0]        in_client,
  input  logic [31:0]        in_client_order,
  input  logic [31:0]        in_target_order,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_report_client,
  output logic [31:0]        out_report_client_order,
  output logic [31:0]        out_report_order,
  output logic [31:0]        out_exec_serial,
  output logic [2:0]         out_exec_kind,
  output logic signed [31:0] out_report_price,
  output logic [31:0]        out_fill_quantity,
  output logic [31:0]        out_leaves_quantity,
  output logic [1:0]         out_reject_code,
  output logic               out_last_report
);
  import lome_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_SCAN   = 4'd2;
  localparam logic [3:0] ST_DECIDE = 4'd3;
  localparam logic [3:0] ST_MAKER  = 4'd4;
  localparam logic [3:0] ST_TAKER  = 4'd5;
  localparam logic [3:0] ST_TAIL   = 4'd6;
  localparam logic [3:0] ST_FREE   = 4'd7;
  localparam logic [3:0] ST_CSCAN1 = 4'd8;
  localparam logic [3:0] ST_CSCAN2 = 4'd9;
  localparam logic [3:0] ST_CDONE  = 4'd10;
  localparam logic [3:0] ST_FINISH = 4'd11;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BOOK_DEPTH - 1);

  logic [3:0]         state_r, state_nxt;
  logic               side_r;
  logic [1:0]         kind_r;
  logic signed [31:0] price_r;
  logic [31:0]        qty_r, cl_r, clord_r, target_r;
  logic [31:0]        eid_r, eid_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [31:0]        m_r, m_nxt;
  logic [31:0]        next_eid_r, next_eid_nxt;
  logic [31:0]        arrival_r, arrival_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               best_v_r, best_v_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  slot_t              best_r, best_nxt;
  logic [31:0]        best_age_r, best_age_nxt;

  book_cmd_t bcmd;
  book_rd_t  brd;
  logic      emit, flush;
  rpt_t      rpt, out_rpt;
  rpt_stat_t stat;

  logic        is_limit, cand, take, better, idx_last;
  logic [31:0] age_i;
  logic [31:0] maker_left;

  lome_book u_book (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (idx_r),
    .cmd    (bcmd),
    .rd     (brd)
  );

  lome_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .rpt        (rpt),
    .flush      (flush),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rpt    (out_rpt),
    .out_serial (out_exec_serial),
    .out_last   (out_last_report)
  );

  assign out_report_client       = out_rpt.client;
  assign out_report_client_order = out_rpt.client_order;
  assign out_report_order        = out_rpt.order;
  assign out_exec_kind           = out_rpt.kind;
  assign out_report_price        = out_rpt.price;
  assign out_fill_quantity       = out_rpt.fill;
  assign out_leaves_quantity     = out_rpt.leaves;
  assign out_reject_code         = out_rpt.code;

  assign in_stall   = (state_r != ST_IDLE);
  assign is_limit   = (kind_r == KIND_LIMIT);
  assign idx_last   = (idx_r == IDX_LAST);
  assign age_i      = arrival_r - brd.data.arrival;
  assign maker_left = best_r.leaves - m_r;

  always_comb begin
    cand = brd.valid && (brd.data.side == !side_r);
    if (!side_r) begin
      better = brd.data.price < best_r.price;
    end else begin
      better = brd.data.price > best_r.price;
    end
    take = cand && (!best_v_r || better ||
                    ((brd.data.price == best_r.price) && (age_i > best_age_r)));
  end

  always_comb begin
    state_nxt    = state_r;
    eid_nxt      = eid_r;
    rem_nxt      = rem_r;
    m_nxt        = m_r;
    next_eid_nxt = next_eid_r;
    arrival_nxt  = arrival_r;
    idx_nxt      = idx_r;
    best_v_nxt   = best_v_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    best_age_nxt = best_age_r;
    emit         = 1'b0;
    flush        = 1'b0;
    rpt          = '{client: cl_r, client_order: clord_r, order: eid_r,
                     kind: EXEC_NEW, price: price_r, fill: 32'd0,
                     leaves: rem_r, code: REJ_NONE};
    bcmd         = '{wr_all: 1'b0, wr_leaves: 1'b0, clr_valid: 1'b0,
                     idx: best_idx_r, data: best_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          idx_nxt    = '0;
          best_v_nxt = 1'b0;
          state_nxt  = (in_command == CMD_NEW) ? ST_CHECK : ST_CSCAN1;
        end
      end
      ST_CHECK: begin
        if (qty_r == 32'd0 || (is_limit && price_r <= 0)) begin
          rpt.order  = 32'd0;
          rpt.kind   = EXEC_REJECTED;
          rpt.leaves = 32'd0;
          rpt.code   = (qty_r == 32'd0) ? REJ_QUANTITY : REJ_PRICE;
          emit       = stat.emit_ok;
          if (stat.emit_ok) begin
            state_nxt = ST_FINISH;
          end
        end else begin
          eid_nxt      = next_eid_r;
          next_eid_nxt = next_eid_r + 32'd1;
          rem_nxt      = qty_r;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (take) begin
          best_v_nxt   = 1'b1;
          best_idx_nxt = idx_r;
          best_nxt     = brd.data;
          best_age_nxt = age_i;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        m_nxt = (rem_r < best_r.leaves) ? rem_r : best_r.leaves;
        if (!best_v_r || (is_limit && (side_r ? (price_r > best_r.price)
                                              : (price_r < best_r.price)))) begin
          state_nxt = ST_TAIL;
        end else begin
          state_nxt = ST_MAKER;
        end
      end
      ST_MAKER: begin
        rpt.client   = best_r.client;
        rpt.client_order = best_r.client_order;
        rpt.order    = best_r.engine_id;
        rpt.kind     = (maker_left == 32'd0) ? EXEC_FILL : EXEC_PARTIAL;
        rpt.price    = best_r.price;
        rpt.fill     = m_r;
        rpt.leaves   = maker_left;
        emit         = stat.emit_ok;
        bcmd.wr_leaves   = stat.emit_ok;
        bcmd.clr_valid   = stat.emit_ok && (maker_left == 32'd0);
        bcmd.data.leaves = maker_left;
        if (stat.emit_ok) begin
          state_nxt = ST_TAKER;
        end
      end
      ST_TAKER: begin
        rem_nxt    = rem_r - m_r;
        rpt.kind   = (rem_nxt == 32'd0) ? EXEC_FILL : EXEC_PARTIAL;
        rpt.price  = best_r.price;
        rpt.fill   = m_r;
        rpt.leaves = rem_nxt;
        emit       = stat.emit_ok;
        if (stat.emit_ok) begin
          best_v_nxt = 1'b0;
          idx_nxt    = '0;
          state_nxt  = (rem_nxt == 32'd0) ? ST_FINISH : ST_SCAN;
        end else begin
          rem_nxt = rem_r;
        end
      end
      ST_TAIL: begin
        if (!is_limit) begin
          rpt.kind = EXEC_CANCELED;
          emit     = stat.emit_ok;
          if (stat.emit_ok) begin
            state_nxt = ST_FINISH;
          end
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_FREE;
        end
      end
      ST_FREE: begin
        if (!brd.valid) begin
          emit                   = stat.emit_ok;
          bcmd.wr_all            = stat.emit_ok;
          bcmd.idx               = idx_r;
          bcmd.data.side         = side_r;
          bcmd.data.price        = price_r;
          bcmd.data.leaves       = rem_r;
          bcmd.data.engine_id    = eid_r;
          bcmd.data.client       = cl_r;
          bcmd.data.client_order = clord_r;
          bcmd.data.arrival      = arrival_r;
          if (stat.emit_ok) begin
            arrival_nxt = arrival_r + 32'd1;
            state_nxt   = ST_FINISH;
          end
        end else if (idx_last) begin
          state_nxt = ST_FINISH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_CSCAN1: begin
        if (target_r != 32'd0 && brd.valid && brd.data.engine_id == target_r) begin
          best_v_nxt   = 1'b1;
          best_idx_nxt = idx_r;
          best_nxt     = brd.data;
          state_nxt    = ST_CDONE;
        end else if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = (clord_r != 32'd0) ? ST_CSCAN2 : ST_CDONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_CSCAN2: begin
        if (brd.valid && brd.data.client_order == clord_r &&
            (!best_v_r || age_i > best_age_r)) begin
          best_v_nxt   = 1'b1;
          best_idx_nxt = idx_r;
          best_nxt     = brd.data;
          best_age_nxt = age_i;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = ST_CDONE;
        end
      end
      ST_CDONE: begin
        if (best_v_r) begin
          rpt.order      = best_r.engine_id;
          rpt.kind       = EXEC_CANCELED;
          rpt.price      = best_r.price;
          rpt.leaves     = best_r.leaves;
          bcmd.clr_valid = stat.emit_ok;
        end else begin
          rpt.order  = target_r;
          rpt.kind   = EXEC_REJECTED;
          rpt.price  = '0;
          rpt.leaves = 32'd0;
          rpt.code   = REJ_NOT_FOUND;
        end
        emit = stat.emit_ok;
        if (stat.emit_ok) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        flush = 1'b1;
        if (stat.flush_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      next_eid_r <= 32'd1;
      arrival_r  <= 32'd0;
      best_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      next_eid_r <= next_eid_nxt;
      arrival_r  <= arrival_nxt;
      best_v_r   <= best_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      side_r   <= in_side;
      kind_r   <= in_order_kind;
      price_r  <= in_limit_price;
      qty_r    <= in_quantity;
      cl_r     <= in_client;
      clord_r  <= in_client_order;
      target_r <= in_target_order;
    end
    eid_r      <= eid_nxt;
    rem_r      <= rem_nxt;
    m_r        <= m_nxt;
    idx_r      <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    best_age_r <= best_age_nxt;
  end

endmodule
